// ===== hdl/array_binary_search_tree_macros.svh =====
// Assertion macros for the tree block.
`ifndef ARRAY_BINARY_SEARCH_TREE_MACROS_SVH
`define ARRAY_BINARY_SEARCH_TREE_MACROS_SVH
`ifndef SYNTHESIS
`define ABST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define ABST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ABST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ABST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hdl/abst_pkg.sv =====
`default_nettype none
package abst_pkg;

	localparam int LEVELS   = 10;
	localparam int SLOT_W   = LEVELS;
	localparam int LVL_W    = $clog2(LEVELS + 1);
	localparam int KEY_W    = 32;
	localparam int HEIGHT_W = 4;
	localparam int STATUS_W = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_IGNORED = 2'd1,
		STATUS_DEEP    = 2'd2
	} abst_status_t;

	typedef struct packed {
		logic clr;
		logic start;
		logic step;
		logic load;
	} abst_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic key_zero;
		logic walk_end;
	} abst_stat_t;

endpackage
`default_nettype wire

// ===== hdl/abst_in_if.sv =====
`default_nettype none
interface abst_in_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic signed [abst_pkg::KEY_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface
`default_nettype wire

// ===== hdl/abst_out_if.sv =====
`default_nettype none
interface abst_out_if;
	logic                             valid;
	logic                             ready;
	logic                             found;
	logic [abst_pkg::STATUS_W-1:0]    status;
	logic [abst_pkg::HEIGHT_W-1:0]    height;

	modport source (output valid, output found, output status, output height, input ready);
	modport sink (input valid, input found, input status, input height, output ready);
endinterface
`default_nettype wire

// ===== hdl/abst_ctrl.sv =====
`default_nettype none
module abst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  abst_pkg::abst_stat_t stat,
	output abst_pkg::abst_cmd_t  cmd
);
	import abst_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_WALK   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = stat.key_zero ? ST_RESULT : ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (stat.walk_end) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/abst_dp.sv =====
`default_nettype none
module abst_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  abst_pkg::abst_cmd_t               cmd,
	output abst_pkg::abst_stat_t              stat,
	input  logic                              in_op,
	input  logic signed [abst_pkg::KEY_W-1:0] in_key,
	output logic                              out_found,
	output logic [abst_pkg::STATUS_W-1:0]     out_status,
	output logic [abst_pkg::HEIGHT_W-1:0]     out_height
);
	import abst_pkg::*;

	logic [KEY_W-1:0]  mem [2**SLOT_W];
	logic [KEY_W-1:0]  rd_q;
	logic [SLOT_W-1:0] rd_addr;
	logic              we;
	logic [SLOT_W-1:0] wr_addr;
	logic [KEY_W-1:0]  wr_data;

	logic [SLOT_W-1:0] clr_q;
	logic [LVL_W-1:0]  height_q;
	logic [KEY_W-1:0]  key_q;
	logic              op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LVL_W-1:0]  level_q;
	logic              res_found_q;
	abst_status_t      res_status_q;
	logic              out_found_q;
	abst_status_t      out_status_q;
	logic [HEIGHT_W-1:0] out_height_q;

	logic              hit;
	logic              empty;
	logic              go_right;
	logic              last;
	logic              walk_end;
	logic              do_insert;
	logic [SLOT_W-1:0] next_slot;
	logic              res_found_d;
	abst_status_t      res_status_d;

	assign hit       = (rd_q == key_q);
	assign empty     = (rd_q == '0);
	assign go_right  = ($signed(key_q) > $signed(rd_q));
	assign last      = (level_q == LVL_W'(LEVELS));
	assign walk_end  = empty || hit || last;
	assign next_slot = {slot_q[SLOT_W-2:0], go_right};
	assign do_insert = cmd.step && empty && (op_q == OP_INSERT);

	assign rd_addr = cmd.start ? SLOT_W'(1) : next_slot;
	assign we      = cmd.clr || do_insert;
	assign wr_addr = cmd.clr ? clr_q : slot_q;
	assign wr_data = cmd.clr ? '0 : key_q;

	assign stat.clr_last = (clr_q == '1);
	assign stat.key_zero = (in_key == '0);
	assign stat.walk_end = walk_end;

	always_comb begin
		res_found_d  = 1'b0;
		res_status_d = STATUS_OK;
		if (empty) begin
			res_status_d = STATUS_OK;
		end else if (hit) begin
			res_found_d  = 1'b1;
			res_status_d = (op_q == OP_SEARCH) ? STATUS_OK : STATUS_IGNORED;
		end else begin
			// walked off the deepest level
			res_status_d = (op_q == OP_SEARCH) ? STATUS_OK : STATUS_DEEP;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			height_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (do_insert && (level_q > height_q)) begin
				height_q <= level_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q        <= in_key;
			op_q         <= in_op;
			slot_q       <= SLOT_W'(1);
			level_q      <= LVL_W'(1);
			res_found_q  <= 1'b0;
			res_status_q <= (in_key == '0) ? STATUS_IGNORED : STATUS_OK;
		end else if (cmd.step) begin
			if (walk_end) begin
				res_found_q  <= res_found_d;
				res_status_q <= res_status_d;
			end else begin
				slot_q  <= next_slot;
				level_q <= level_q + LVL_W'(1);
			end
		end
		if (cmd.load) begin
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
			out_height_q <= HEIGHT_W'(height_q);
		end
	end

	assign out_found  = out_found_q;
	assign out_status = out_status_q;
	assign out_height = out_height_q;

endmodule
`default_nettype wire

// ===== hdl/array_binary_search_tree.sv =====
// Channel | Direction | Word
// in      | sink      | op, key
// out     | source    | found, status, height
//
// A word other than a zero key walks from 1 to 10 levels of the tree.
// The walk does one synchronous read of the node memory per level.
// A zero key skips the walk.
// After reset a clearing pass zeroes the 1024 slots; in.ready is low meanwhile.
// A finished word waits in the output register; the next word is taken meanwhile.
`default_nettype none
`include "array_binary_search_tree_macros.svh"
module array_binary_search_tree (
	input  logic      clk,
	input  logic      arst_n,
	abst_in_if.sink   in,
	abst_out_if.source out
);
	import abst_pkg::*;

	abst_cmd_t  cmd;
	abst_stat_t stat;

	abst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	abst_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (in.op),
		.in_key     (in.key),
		.out_found  (out.found),
		.out_status (out.status),
		.out_height (out.height)
	);

	`ABST_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, cmd.clr, !in.ready, "word accepted during clearing pass")
	`ABST_ASSERT_IMP(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd), "more than one datapath command")
	`ABST_ASSERT_NXT(a_load_valid, clk, arst_n, cmd.load, out.valid, "loaded result not presented")
	`ABST_ASSERT_IMP(a_status_code, clk, arst_n, out.valid, out.status != 2'd3, "undefined status code")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import abst_pkg::*;

	localparam int NODE_SLOTS   = 1 << LEVELS;
	localparam int RANDOM_WORDS = 1400;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

	typedef struct {
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [HEIGHT_W-1:0] height;
	} tree_result_t;

	typedef struct {
		logic             op;
		logic [KEY_W-1:0] key;
		bit               typed;
		logic             found;
		abst_status_t     status;
		int               height;
	} dir_row_t;

	localparam int DIR_ROWS = 24;

	// Root 1000, the extremes as its children, then a chain under KEY_MAX down to the last level.
	dir_row_t dir_table [0:DIR_ROWS-1] = '{
		'{OP_SEARCH, 32'd5,        1'b1, 1'b0, STATUS_OK,      0},
		'{OP_INSERT, 32'd0,        1'b1, 1'b0, STATUS_IGNORED, 0},
		'{OP_SEARCH, 32'd0,        1'b1, 1'b0, STATUS_IGNORED, 0},
		'{OP_INSERT, 32'd1000,     1'b1, 1'b0, STATUS_OK,      1},
		'{OP_INSERT, KEY_MIN,      1'b1, 1'b0, STATUS_OK,      2},
		'{OP_INSERT, KEY_MAX,      1'b1, 1'b0, STATUS_OK,      2},
		'{OP_INSERT, KEY_MIN,      1'b1, 1'b1, STATUS_IGNORED, 2},
		'{OP_SEARCH, KEY_MAX,      1'b1, 1'b1, STATUS_OK,      2},
		'{OP_SEARCH, KEY_MIN + 1,  1'b1, 1'b0, STATUS_OK,      2},
		'{OP_INSERT, KEY_MAX - 9,  1'b1, 1'b0, STATUS_OK,      3},
		'{OP_INSERT, KEY_MAX - 8,  1'b1, 1'b0, STATUS_OK,      4},
		'{OP_INSERT, KEY_MAX - 7,  1'b1, 1'b0, STATUS_OK,      5},
		'{OP_INSERT, KEY_MAX - 6,  1'b1, 1'b0, STATUS_OK,      6},
		'{OP_INSERT, KEY_MAX - 5,  1'b1, 1'b0, STATUS_OK,      7},
		'{OP_INSERT, KEY_MAX - 4,  1'b1, 1'b0, STATUS_OK,      8},
		'{OP_INSERT, KEY_MAX - 3,  1'b1, 1'b0, STATUS_OK,      9},
		'{OP_INSERT, KEY_MAX - 2,  1'b1, 1'b0, STATUS_OK,      10},
		'{OP_INSERT, KEY_MAX - 1,  1'b1, 1'b0, STATUS_DEEP,    10},
		'{OP_SEARCH, KEY_MAX - 1,  1'b1, 1'b0, STATUS_OK,      10},
		'{OP_SEARCH, KEY_MAX - 2,  1'b1, 1'b1, STATUS_OK,      10},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, STATUS_OK,     0},
		'{OP_SEARCH, 32'hFFFF_FFFF, 1'b0, 1'b0, STATUS_OK,     0},
		'{OP_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, STATUS_OK,     0},
		'{OP_INSERT, 32'h5555_5555, 1'b0, 1'b0, STATUS_OK,     0}
	};

	logic clk;
	logic arst_n;

	abst_in_if  cmd_bus ();
	abst_out_if res_bus ();

	array_binary_search_tree uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (cmd_bus),
		.out    (res_bus)
	);

	logic signed [KEY_W-1:0] node_copy [0:NODE_SLOTS-1];
	int unsigned             height_copy;
	tree_result_t            expected_words [$];
	logic [KEY_W-1:0]        key_pool [$];

	int  words_sent;
	int  mismatches;
	int  idle_cycles = 0;
	bit  calm;
	bit  held_off;
	int  n_stored, n_ignored, n_deep, n_hits, n_misses;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly back to back, sometimes a few cycles, rarely a long gap.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic tree_result_t apply_to_tree(logic op, logic signed [KEY_W-1:0] key);
		tree_result_t r;
		int unsigned  slot;
		int unsigned  lvl;
		bit           hit;
		bit           empty;
		r.found  = 1'b0;
		r.status = STATUS_OK;
		if (key == 0) begin
			r.status = STATUS_IGNORED;
			n_ignored++;
		end else begin
			slot  = 1;
			lvl   = 1;
			hit   = 1'b0;
			empty = 1'b0;
			while (lvl <= LEVELS && !hit && !empty) begin
				if (node_copy[slot] == 0)
					empty = 1'b1;
				else if (key == node_copy[slot])
					hit = 1'b1;
				else begin
					slot = (key > node_copy[slot]) ? 2 * slot + 1 : 2 * slot;
					lvl++;
				end
			end
			if (op == OP_SEARCH) begin
				r.found = hit;
				if (hit)
					n_hits++;
				else
					n_misses++;
			end else if (hit) begin
				r.found  = 1'b1;
				r.status = STATUS_IGNORED;
				n_ignored++;
			end else if (!empty) begin
				r.status = STATUS_DEEP;
				n_deep++;
			end else begin
				node_copy[slot] = key;
				if (lvl > height_copy)
					height_copy = lvl;
				n_stored++;
			end
		end
		r.height = height_copy[HEIGHT_W-1:0];
		return r;
	endfunction

	task automatic send_word(input logic op, input logic [KEY_W-1:0] key, input bit typed,
			input tree_result_t typed_result);
		int           gap;
		tree_result_t predicted;
		gap = calm ? 0 : idle_len();
		repeat (gap) begin
			@(negedge clk);
			cmd_bus.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_bus.valid <= 1'b1;
		cmd_bus.op    <= op;
		cmd_bus.key   <= key;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		predicted = apply_to_tree(op, key);
		expected_words.push_back(typed ? typed_result : predicted);
		if (op == OP_INSERT && key != 0)
			key_pool.push_back(key);
		words_sent++;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		else if (r < 45 || key_pool.size() == 0)
			return $urandom;
		else if (r < 72)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (r < 87)
			return $urandom_range(0, 4000) - 2000;
		else if (r < 93)
			return KEY_MAX - $urandom_range(0, 15);
		return KEY_MIN + $urandom_range(0, 15);
	endfunction

	initial begin
		tree_result_t typed_result;
		arst_n        = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.op    = OP_INSERT;
		cmd_bus.key   = '0;
		calm          = 1'b0;
		words_sent    = 0;
		mismatches    = 0;
		height_copy   = 0;
		n_stored      = 0;
		n_ignored     = 0;
		n_deep        = 0;
		n_hits        = 0;
		n_misses      = 0;
		for (int i = 0; i < NODE_SLOTS; i++)
			node_copy[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[i]) begin
			typed_result.found  = dir_table[i].found;
			typed_result.status = dir_table[i].status;
			typed_result.height = dir_table[i].height[HEIGHT_W-1:0];
			send_word(dir_table[i].op, dir_table[i].key, dir_table[i].typed, typed_result);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= 400 && n < 600);
			send_word($urandom_range(0, 1), pick_key(), 1'b0, typed_result);
		end
		calm = 1'b0;
		@(negedge clk);
		cmd_bus.valid <= 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Sent %0d words: %0d keys stored, %0d duplicate or zero keys, %0d too deep",
			words_sent, n_stored, n_ignored, n_deep);
		$display("Searches: %0d hits, %0d misses; final height %0d",
			n_hits, n_misses, height_copy);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: random stalls, a no-stall window, and one long hold-off to back up the block.
	initial begin
		int n;
		res_bus.ready = 1'b0;
		held_off      = 1'b0;
		wait (arst_n);
		forever begin
			if (!held_off && words_sent >= DIR_ROWS + 900) begin
				held_off = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk) res_bus.ready <= 1'b0;
			end else if (calm) begin
				@(negedge clk) res_bus.ready <= 1'b1;
			end else begin
				n = idle_len();
				repeat (n) @(negedge clk) res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk) res_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		tree_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing outstanding: found %0d status %0d height %0d",
					res_bus.found, res_bus.status, res_bus.height);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (res_bus.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, res_bus.found);
					mismatches++;
				end
				if (res_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_bus.status);
					mismatches++;
				end
				if (res_bus.height !== want.height) begin
					$error("height: expected %0d, got %0d", want.height, res_bus.height);
					mismatches++;
				end
			end
		end
	end

	// The clearing pass after reset counts as idle, so the limit covers it.
	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, expected_words.size());
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/abst_pkg.sv
hdl/abst_in_if.sv
hdl/abst_out_if.sv
hdl/abst_ctrl.sv
hdl/abst_dp.sv
hdl/array_binary_search_tree.sv
tb/testbench.sv
